>>> hw/rtl/neighbor_list_builder_core_assert.svh
// Assertion macros shared by the neighbor list builder.
`ifndef NEIGHBOR_LIST_BUILDER_CORE_ASSERT_SVH
`define NEIGHBOR_LIST_BUILDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define NLB_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define NLB_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define NLB_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define NLB_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif

`endif

>>> hw/rtl/nlb_pkg.sv
package nlb_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int PIDX_W        = 6;
    localparam int COUNT_W       = 7;
    localparam int LIST_SLOTS    = 4096;
    localparam int SLOT_W        = 12;
    localparam int LEN_W         = 13;
    localparam int COORD_BITS    = 24;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int SQ_W          = 2 * DIFF_W;
    localparam int RANGE_W       = 52;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SQ        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIST_LENGTH = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BUILD = 1'b1;

    typedef struct packed {
        logic                         opcode;
        logic [PIDX_W-1:0]            index;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [PIDX_W-1:0] neighbor_index;
        logic [SLOT_W-1:0] slot;
        logic              has_neighbor;
        logic [SLOT_W-1:0] row_start;
        logic              overflow;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } coord_t;

    // Candidate handed from the cell chain to the distance pipeline.
    typedef struct packed {
        logic              cand;
        logic [PIDX_W-1:0] j;
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

endpackage

>>> hw/rtl/neighbor_list_builder_core.sv
// Load beats write one cell and leave the core ready for the next beat. A
// build beat rotates all 64 cells once past a three-stage distance pipeline,
// one pair compared per cycle while the output does not stall. The next beat
// can be accepted in the same cycle that the final beat of the row is presented.
// Reset clears control state, the list length and the overflow flag, and sets
// the registers to count 64, range 0, max length 4095; positions are not reset.
module neighbor_list_builder_core
    import nlb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data
);

`include "neighbor_list_builder_core_assert.svh"

    logic [COUNT_W-1:0] count_reg;
    logic [RANGE_W-1:0] range_reg;
    logic [SLOT_W-1:0]  max_len_reg;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [PIDX_W-1:0]  row_reg;
    coord_t             ref_reg;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [SLOT_W-1:0]  start_reg;
    out_item_t          pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    coord_t             cell_pos [MAX_PARTICLES];
    logic               advance, shift, in_acc;
    logic [COUNT_W-1:0] count_eff;
    logic [LEN_W-1:0]   len_base;
    tag_t               tag;
    logic               hit;
    logic [PIDX_W-1:0]  hit_j;
    logic               push;
    out_item_t          push_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign advance   = !out_valid_reg || out_ready;
    assign shift     = (state_reg == ST_SCAN) && advance && !cnt_reg[COUNT_W-1];
    assign count_eff = (count_reg > COUNT_W'(MAX_PARTICLES)) ?
                       COUNT_W'(MAX_PARTICLES) : count_reg;

    // Rotates one cell per cycle while shifting; cell 0 holds particle cnt.
    genvar g;
    generate
        for (g = 0; g < MAX_PARTICLES; g++)
        begin : g_cell
            nlb_cell u_cell (
                .clk       (clk),
                .shift     (shift),
                .load      (in_acc && (in_data.opcode == OP_LOAD) &&
                            (in_data.index == PIDX_W'(g))),
                .load_pos  ({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
                .from_next (cell_pos[(g + 1) % MAX_PARTICLES]),
                .pos       (cell_pos[g])
            );
        end
    endgenerate

    always_comb
    begin
        tag.j    = cnt_reg[PIDX_W-1:0];
        tag.cand = shift && (tag.j > row_reg) &&
                   ({1'b0, tag.j} < count_eff);
    end

    nlb_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       ((state_reg == ST_SCAN) && advance),
        .ref_pos  (ref_reg),
        .cand_pos (cell_pos[0]),
        .tag_in   (tag),
        .range_sq (range_reg),
        .hit      (hit),
        .hit_j    (hit_j)
    );

    assign len_base = (in_data.index == '0) ? '0 : len_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_data       = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.opcode == OP_BUILD))
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    len_next   = len_base;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == COUNT_W'(MAX_PARTICLES + 2))
                    begin
                        state_next = ST_FIN;
                    end
                    if (hit)
                    begin
                        if (len_reg > {1'b0, max_len_reg})
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            push = pend_valid_reg;
                            pend_next.neighbor_index = hit_j;
                            pend_next.slot           = len_reg[SLOT_W-1:0];
                            pend_next.has_neighbor   = 1'b1;
                            pend_next.row_start      = start_reg;
                            pend_next.overflow       = ovf_reg;
                            pend_next.last           = 1'b0;
                            pend_valid_next          = 1'b1;
                            len_next                 = len_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                if (advance)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        push_data.overflow = ovf_reg;
                        push_data.last     = 1'b1;
                    end
                    else
                    begin
                        push_data.neighbor_index = '0;
                        push_data.slot           = '0;
                        push_data.has_neighbor   = 1'b0;
                        push_data.row_start      = start_reg;
                        push_data.overflow       = ovf_reg;
                        push_data.last           = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= COUNT_W'(MAX_PARTICLES);
            range_reg      <= '0;
            max_len_reg    <= SLOT_W'(LIST_SLOTS - 1);
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PARTICLE_COUNT:  count_reg   <= cfg_data[COUNT_W-1:0];
                    CFG_RANGE_SQ:        range_reg   <= cfg_data;
                    CFG_MAX_LIST_LENGTH: max_len_reg <= cfg_data[SLOT_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (in_acc && (in_data.opcode == OP_BUILD))
        begin
            row_reg   <= in_data.index;
            ref_reg   <= cell_pos[in_data.index];
            start_reg <= len_base[SLOT_W] ? SLOT_W'(LIST_SLOTS - 1) :
                                            len_base[SLOT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `NLB_ASSERT_IMP(a_idle_no_pending, clk, rst_n, in_ready, !pend_valid_reg)
    `NLB_ASSERT_IMP(a_scan_count, clk, rst_n, state_reg == ST_SCAN,
                    cnt_reg <= COUNT_W'(MAX_PARTICLES + 2))
    `NLB_ASSERT_IMP(a_empty_is_last, clk, rst_n,
                    out_valid && !out_data.has_neighbor, out_data.last)
    `NLB_ASSERT_NXT(a_fin_emits, clk, rst_n, (state_reg == ST_FIN) && advance,
                    out_valid && out_data.last)

endmodule

>>> hw/rtl/nlb_cell.sv
module nlb_cell
    import nlb_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  logic   load,
    input  coord_t load_pos,
    input  coord_t from_next,
    output coord_t pos
);

    coord_t pos_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= load_pos;
        end
        else if (shift)
        begin
            pos_reg <= from_next;
        end
    end

    assign pos = pos_reg;

endmodule

>>> hw/rtl/nlb_dist.sv
module nlb_dist
    import nlb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  coord_t             ref_pos,
    input  coord_t             cand_pos,
    input  tag_t               tag_in,
    input  logic [RANGE_W-1:0] range_sq,
    output logic               hit,
    output logic [PIDX_W-1:0]  hit_j
);

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]          sx_reg, sy_reg, sz_reg;
    tag_t                     t1_reg, t2_reg;
    logic                     hit_reg;
    logic [PIDX_W-1:0]        j3_reg;
    logic [RANGE_W-1:0]       sum;

    assign sum = RANGE_W'(sx_reg) + RANGE_W'(sy_reg) + RANGE_W'(sz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DIFF_W'(ref_pos.x) - DIFF_W'(cand_pos.x);
            dy_reg <= DIFF_W'(ref_pos.y) - DIFF_W'(cand_pos.y);
            dz_reg <= DIFF_W'(ref_pos.z) - DIFF_W'(cand_pos.z);
            sx_reg <= SQ_W'(dx_reg * dx_reg);
            sy_reg <= SQ_W'(dy_reg * dy_reg);
            sz_reg <= SQ_W'(dz_reg * dz_reg);
            j3_reg <= t2_reg.j;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            hit_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_reg  <= tag_in;
            t2_reg  <= t1_reg;
            hit_reg <= t2_reg.cand && (sum <= range_sq);
        end
    end

    assign hit   = hit_reg;
    assign hit_j = j3_reg;

endmodule
